// ===== rtl/kinematic_apogee_predictor_top_assert.svh =====
// assertion macros for the kinematic apogee predictor
// expects signals named clock and reset in the including scope
`ifndef KINEMATIC_APOGEE_PREDICTOR_TOP_ASSERT_SVH
`define KINEMATIC_APOGEE_PREDICTOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KAP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("kap assertion failed");
`define KAP_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("kap forbidden condition seen");
`else
`define KAP_ASSERT(label, prop)
`define KAP_NEVER(label, cond)
`endif
`endif

// ===== rtl/kap_pkg.sv =====
// shared types and constants for the kinematic apogee predictor
// no dependencies
`default_nettype none
package kap_pkg;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned PROD_W     = 64;
   localparam int unsigned DIVD_W     = 48;
   localparam int unsigned DIV_STEPS  = DIVD_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int unsigned WEIGHT_W   = 17;
   localparam logic [WEIGHT_W-1:0] ONE_Q16     = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = 17'd13107;
   localparam logic [WORD_W-1:0]   MS_PER_S    = 32'd1000;
   localparam logic [PROD_W-1:0]   ROUND_HALF  = 64'd32768;

   // register indexes
   localparam logic REG_FILTER_WEIGHT = 1'b0;
   localparam logic REG_MIN_CLIMB     = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_DV, ST_DIV_DV, ST_WAIT_DV, ST_AVG, ST_MUL_NEW, ST_MUL_OLD,
      ST_FILT, ST_CHECK, ST_DIV_T, ST_WAIT_T, ST_MUL_MS, ST_MUL_DT, ST_MUL_VT,
      ST_MUL_PT, ST_ALT, ST_DONE
   } kap_state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_MUL_DV, CMD_DIV_DV, CMD_AVG, CMD_MUL_NEW,
      CMD_MUL_OLD, CMD_FILT, CMD_CHECK, CMD_DIV_T, CMD_TAKE_T, CMD_MUL_MS,
      CMD_MUL_DT, CMD_MUL_VT, CMD_MUL_PT, CMD_ALT, CMD_OUT
   } kap_cmd_type;

   typedef struct packed {
      logic ts_adv;
      logic dv_neg;
      logic pred_valid;
      logic v_pos;
      logic div_busy;
      logic div_done;
   } kap_status_type;
endpackage
`default_nettype wire

// ===== rtl/kap_div.sv =====
// restoring divider, one quotient bit per cycle, saturating 32-bit quotient
// depends on kap_pkg
`default_nettype none
module kap_div
   import kap_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [WORD_W-1:0] divisor,
   output logic                   busy,
   output logic                   done,
   output logic [WORD_W-1:0]      quotient
);
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [WORD_W:0]      shifted;
   logic                 fits;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVD_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
   end

   // control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // payload
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? WORD_W'(shifted - {1'b0, dsr_ff}) : shifted[WORD_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = (|quo_ff[DIVD_W-1:WORD_W]) ? '1 : quo_ff[WORD_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/kap_datapath.sv =====
// datapath: sample registers, filter state, shared multiplier and divider
// depends on kap_pkg and kap_div
`default_nettype none
module kap_datapath
   import kap_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire kap_cmd_type        cmd,
   output kap_status_type          status,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_index,
   input  wire logic [WORD_W-1:0]  csr_write_data,
   input  wire logic [WORD_W-1:0]  req_timestamp_ms,
   input  wire logic signed [WORD_W-1:0] req_velocity,
   input  wire logic signed [WORD_W-1:0] req_acceleration,
   input  wire logic signed [WORD_W-1:0] req_altitude,
   output logic                    rsp_prediction_valid,
   output logic [WORD_W-1:0]       rsp_time_to_apogee,
   output logic [WORD_W-1:0]       rsp_apogee_timestamp,
   output logic signed [WORD_W-1:0] rsp_apogee_altitude,
   output logic [WORD_W-1:0]       rsp_filtered_decel
);
   // configuration
   logic [WEIGHT_W-1:0]      alpha_ff;
   logic signed [WORD_W-1:0] minv_ff;
   // filter and history state
   logic [WORD_W-1:0]        df_ff, prev_ts_ff;
   logic signed [WORD_W-1:0] prev_v_ff;
   // per-sample working registers
   logic [WORD_W-1:0]        ts_ff, dt_ff, dv_mag_ff, sample_ff, t_ff, p_ff, apo_ts_ff;
   logic signed [WORD_W-1:0] v_ff, alt_ff, apo_alt_ff;
   logic                     ts_adv_ff, dv_neg_ff, valid_ff;
   logic [PROD_W-1:0]        prod_ff, acc_ff, vt_ff;
   // outputs
   logic                     o_valid_ff;
   logic [WORD_W-1:0]        o_t_ff, o_ts_ff, o_df_ff;
   logic signed [WORD_W-1:0] o_alt_ff;

   logic [WORD_W-1:0]        mul_a, mul_b, est, vu, raw, div_q;
   logic [DIVD_W-1:0]        div_dividend;
   logic [WORD_W-1:0]        div_divisor;
   logic                     div_start, div_busy, div_done;
   logic signed [WORD_W:0]   dv;
   logic [WORD_W:0]          avg_sum, ts_sum;
   logic [PROD_W+1:0]        filt_sum;
   logic [PROD_W-1:0]        alt_diff;
   logic signed [WORD_W+8:0] alt_sum;
   logic [WEIGHT_W-1:0]      wdata;

   assign vu  = {1'b0, v_ff[WORD_W-2:0]};
   assign dv  = (WORD_W+1)'(req_velocity) - (WORD_W+1)'(prev_v_ff);
   assign raw = req_acceleration[WORD_W-1] ? WORD_W'(-req_acceleration) : '0;
   assign est = dv_neg_ff ? div_q : '0;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd)
         CMD_MUL_DV:  begin mul_a = dv_mag_ff; mul_b = MS_PER_S; end
         CMD_MUL_NEW: begin mul_a = WORD_W'(alpha_ff); mul_b = sample_ff; end
         CMD_MUL_OLD: begin mul_a = WORD_W'(ONE_Q16 - alpha_ff); mul_b = df_ff; end
         CMD_MUL_MS:  begin mul_a = t_ff; mul_b = MS_PER_S; end
         CMD_MUL_DT:  begin mul_a = df_ff; mul_b = t_ff; end
         CMD_MUL_VT:  begin mul_a = vu; mul_b = t_ff; end
         CMD_MUL_PT:  begin mul_a = p_ff; mul_b = t_ff; end
         default:     begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // divider operand select
   assign div_start    = (cmd == CMD_DIV_DV) || (cmd == CMD_DIV_T);
   assign div_dividend = (cmd == CMD_DIV_T) ? {1'b0, v_ff[WORD_W-2:0], 16'd0}
                                            : prod_ff[DIVD_W-1:0];
   assign div_divisor  = (cmd == CMD_DIV_T) ? df_ff : dt_ff;

   kap_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // arithmetic helpers
   always_comb begin
      avg_sum  = {1'b0, sample_ff} + {1'b0, est};
      filt_sum = {2'b0, acc_ff} + {2'b0, prod_ff} + {2'b0, ROUND_HALF};
      ts_sum   = {1'b0, ts_ff} + (WORD_W+1)'(prod_ff[41:16]);
      alt_diff = vt_ff - {1'b0, prod_ff[PROD_W-1:1]};
      alt_sum  = (WORD_W+9)'(alt_ff) + $signed({1'b0, alt_diff[PROD_W-1:24]});
      wdata    = csr_write_data[WEIGHT_W-1:0];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= WEIGHT_RST;
         minv_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FILTER_WEIGHT: alpha_ff <= (wdata > ONE_Q16) ? ONE_Q16 : wdata;
            REG_MIN_CLIMB:     minv_ff  <= $signed(csr_write_data);
            default:           alpha_ff <= alpha_ff;
         endcase
      end
   end

   // filter and history state
   always_ff @(posedge clock) begin
      if (reset) begin
         df_ff      <= '0;
         prev_ts_ff <= '0;
         prev_v_ff  <= '0;
      end else begin
         if (cmd == CMD_LOAD) begin
            prev_ts_ff <= req_timestamp_ms;
            prev_v_ff  <= req_velocity;
         end
         if (cmd == CMD_FILT)
            df_ff <= (|filt_sum[PROD_W+1:48]) ? '1 : filt_sum[47:16];
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      unique case (cmd)
         CMD_LOAD: begin
            ts_ff     <= req_timestamp_ms;
            v_ff      <= req_velocity;
            alt_ff    <= req_altitude;
            sample_ff <= raw;
            dt_ff     <= req_timestamp_ms - prev_ts_ff;
            dv_mag_ff <= WORD_W'(-dv);
            ts_adv_ff <= req_timestamp_ms > prev_ts_ff;
            dv_neg_ff <= (req_timestamp_ms > prev_ts_ff) && dv[WORD_W];
         end
         CMD_AVG:     sample_ff <= avg_sum[WORD_W:1];
         CMD_MUL_OLD: acc_ff <= prod_ff;
         CMD_CHECK:   valid_ff <= status.pred_valid;
         CMD_TAKE_T:  t_ff <= div_q;
         CMD_MUL_DT:  apo_ts_ff <= ts_sum[WORD_W] ? '1 : ts_sum[WORD_W-1:0];
         CMD_MUL_VT:  p_ff <= prod_ff[47:16];
         CMD_MUL_PT:  vt_ff <= prod_ff;
         CMD_ALT:     apo_alt_ff <= (alt_sum > (WORD_W+9)'(32'sh7FFFFFFF))
                                    ? 32'sh7FFFFFFF : alt_sum[WORD_W-1:0];
         default:     ts_ff <= ts_ff;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd == CMD_OUT) begin
         o_valid_ff <= valid_ff;
         o_df_ff    <= df_ff;
         if (!valid_ff) begin
            o_t_ff   <= '0;
            o_ts_ff  <= '0;
            o_alt_ff <= '0;
         end else if (!v_ff[WORD_W-1] && v_ff != '0) begin
            o_t_ff   <= t_ff;
            o_ts_ff  <= apo_ts_ff;
            o_alt_ff <= apo_alt_ff;
         end else begin
            o_t_ff   <= '0;
            o_ts_ff  <= ts_ff;
            o_alt_ff <= alt_ff;
         end
      end
   end

   // status to the controller
   always_comb begin
      status.ts_adv     = ts_adv_ff;
      status.dv_neg     = dv_neg_ff;
      status.pred_valid = (v_ff > minv_ff) && (df_ff != '0);
      status.v_pos      = !v_ff[WORD_W-1] && (v_ff != '0);
      status.div_busy   = div_busy;
      status.div_done   = div_done;
   end

   assign rsp_prediction_valid = o_valid_ff;
   assign rsp_time_to_apogee   = o_t_ff;
   assign rsp_apogee_timestamp = o_ts_ff;
   assign rsp_apogee_altitude  = o_alt_ff;
   assign rsp_filtered_decel   = o_df_ff;
endmodule
`default_nettype wire

// ===== rtl/kap_ctrl.sv =====
// controller state machine sequencing the datapath for one sample
// depends on kap_pkg and the assertion macro header
`default_nettype none
`include "kinematic_apogee_predictor_top_assert.svh"
module kap_ctrl
   import kap_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire kap_status_type status,
   output kap_cmd_type         cmd
);
   kap_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL_DV;
         ST_MUL_DV: begin
            if (!status.ts_adv)     state_in = ST_MUL_NEW;
            else if (!status.dv_neg) state_in = ST_AVG;
            else                    state_in = ST_DIV_DV;
         end
         ST_DIV_DV:  state_in = ST_WAIT_DV;
         ST_WAIT_DV: if (status.div_done) state_in = ST_MUL_NEW;
         ST_AVG:     state_in = ST_MUL_NEW;
         ST_MUL_NEW: state_in = ST_MUL_OLD;
         ST_MUL_OLD: state_in = ST_FILT;
         ST_FILT:    state_in = ST_CHECK;
         ST_CHECK:   state_in = (status.pred_valid && status.v_pos) ? ST_DIV_T : ST_DONE;
         ST_DIV_T:   state_in = ST_WAIT_T;
         ST_WAIT_T:  if (status.div_done) state_in = ST_MUL_MS;
         ST_MUL_MS:  state_in = ST_MUL_DT;
         ST_MUL_DT:  state_in = ST_MUL_VT;
         ST_MUL_VT:  state_in = ST_MUL_PT;
         ST_MUL_PT:  state_in = ST_ALT;
         ST_ALT:     state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = CMD_NONE;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) cmd = CMD_LOAD;
         ST_MUL_DV:  if (status.dv_neg) cmd = CMD_MUL_DV;
         ST_DIV_DV:  cmd = CMD_DIV_DV;
         ST_WAIT_DV: if (status.div_done) cmd = CMD_AVG;
         ST_AVG:     cmd = CMD_AVG;
         ST_MUL_NEW: cmd = CMD_MUL_NEW;
         ST_MUL_OLD: cmd = CMD_MUL_OLD;
         ST_FILT:    cmd = CMD_FILT;
         ST_CHECK:   cmd = CMD_CHECK;
         ST_DIV_T:   cmd = CMD_DIV_T;
         ST_WAIT_T:  if (status.div_done) cmd = CMD_TAKE_T;
         ST_MUL_MS:  cmd = CMD_MUL_MS;
         ST_MUL_DT:  cmd = CMD_MUL_DT;
         ST_MUL_VT:  cmd = CMD_MUL_VT;
         ST_MUL_PT:  cmd = CMD_MUL_PT;
         ST_ALT:     cmd = CMD_ALT;
         ST_DONE:    if (out_free) cmd = CMD_OUT;
         default:    cmd = CMD_NONE;
      endcase
   end

   // result beat pending flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd == CMD_OUT)             rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `KAP_NEVER(a_no_overwrite, (cmd == CMD_OUT) && rsp_valid_ff && rsp_stall)
   `KAP_NEVER(a_no_restart, (cmd == CMD_DIV_DV || cmd == CMD_DIV_T) && status.div_busy)
   `KAP_ASSERT(a_out_then_idle, (cmd == CMD_OUT) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
endmodule
`default_nettype wire

// ===== rtl/kinematic_apogee_predictor_top.sv =====
// top level of the kinematic apogee predictor
// depends on kap_pkg, kap_ctrl, kap_datapath, kap_div
//
//  channel  | direction | handshake          | payload
//  req_     | in        | req_valid/stall    | timestamp, velocity, accel, altitude
//  rsp_     | out       | rsp_valid/stall    | valid, time, timestamp, altitude, decel
//  csr_     | in        | csr_write_enable   | csr_index, csr_write_data
//
// one sample at a time; the derived decel division runs only when the timestamp advances
// with falling velocity, and the time to apogee division and climb prediction run only when
// the prediction is valid and velocity is positive; the next accept comes back in idle
// the two serial divisions (derived decel, time to apogee) take 48 steps each
// synchronous reset clears filter state, history and the pending result beat
// a stalled result beat holds the last state until taken; req_stall is high while busy
`default_nettype none
module kinematic_apogee_predictor_top
   import kap_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [WORD_W-1:0]        req_timestamp_ms,
   input  wire logic signed [WORD_W-1:0] req_velocity,
   input  wire logic signed [WORD_W-1:0] req_acceleration,
   input  wire logic signed [WORD_W-1:0] req_altitude,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_prediction_valid,
   output logic [WORD_W-1:0]             rsp_time_to_apogee,
   output logic [WORD_W-1:0]             rsp_apogee_timestamp,
   output logic signed [WORD_W-1:0]      rsp_apogee_altitude,
   output logic [WORD_W-1:0]             rsp_filtered_decel,
   input  wire logic                     csr_write_enable,
   input  wire logic                     csr_index,
   input  wire logic [WORD_W-1:0]        csr_write_data
);
   kap_cmd_type    cmd;
   kap_status_type status;

   // sequencer
   kap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   kap_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_timestamp_ms     (req_timestamp_ms),
      .req_velocity         (req_velocity),
      .req_acceleration     (req_acceleration),
      .req_altitude         (req_altitude),
      .rsp_prediction_valid (rsp_prediction_valid),
      .rsp_time_to_apogee   (rsp_time_to_apogee),
      .rsp_apogee_timestamp (rsp_apogee_timestamp),
      .rsp_apogee_altitude  (rsp_apogee_altitude),
      .rsp_filtered_decel   (rsp_filtered_decel)
   );
endmodule
`default_nettype wire
